[rtl/sps_pkg.sv]
// Shared types and constants of the segmented prime sieve.
// No dependencies; compile first.
package sps_pkg;

   localparam int START_W = 24;
   localparam int LEN_W   = 7;
   localparam int MASK_W  = 64;
   localparam int COUNT_W = 7;

   localparam int DEF_WINDOW_BITS      = 64;
   localparam int DEF_BASE_LIMIT       = 4096;
   localparam int DEF_BASE_TABLE_DEPTH = 564;

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_BSTRIKE,
      ST_WIN_INIT,
      ST_P_RD,
      ST_P_LOAD,
      ST_P_SQ,
      ST_P_CMP,
      ST_P_DIV,
      ST_P_OFF,
      ST_WSTRIKE,
      ST_DONE
   } sps_state_type;

endpackage

[rtl/sps_req_if.sv]
// Request channel: one window start per word.
// Depends on sps_pkg.
interface sps_req_if import sps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [START_W-1:0] window_start;

   modport source (output valid, output window_start, input ready);
   modport sink   (input valid, input window_start, output ready);
endinterface

[rtl/sps_rsp_if.sv]
// Response channel: prime bitmap and prime count per word.
// Depends on sps_pkg.
interface sps_rsp_if import sps_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MASK_W-1:0]  prime_mask;
   logic [COUNT_W-1:0] prime_count;

   modport source (output valid, output prime_mask, output prime_count, input ready);
   modport sink   (input valid, input prime_mask, input prime_count, output ready);
endinterface

[rtl/segmented_prime_sieve.sv]
// Segmented sieve of Eratosthenes over a window of consecutive integers.
// Depends on sps_pkg, sps_req_if, sps_rsp_if and sps_ram.
//
//   channel   direction  words carried
//   req_bus   in         window_start
//   rsp_bus   out        prime_mask, prime_count
//   csr_*     in         window_length (write only)
//
// First request after reset builds the base prime table: a clear sweep of the mark RAM,
// then a scan that strikes the multiples of each prime p from p*p upward.
// Each window: per base prime p with p*p <= window end, a square, a bit-serial remainder
// of the window start by p, and a strike of each multiple of p in the window.
// The shared squarer and remainder unit serve one prime at a time; req_ready is low meanwhile.
// A finished word waits in the output register; a new request is taken while it waits.
module segmented_prime_sieve import sps_pkg::*; #(
   parameter int WINDOW_BITS      = DEF_WINDOW_BITS,
   parameter int BASE_LIMIT       = DEF_BASE_LIMIT,
   parameter int BASE_TABLE_DEPTH = DEF_BASE_TABLE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   sps_req_if.sink          req_bus,
   sps_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   localparam int PW   = $clog2(BASE_LIMIT);
   localparam int IW   = PW + 1;
   localparam int KW   = $clog2(BASE_TABLE_DEPTH + 1);
   localparam int TAW  = $clog2(BASE_TABLE_DEPTH);
   localparam int WIW  = $clog2(WINDOW_BITS);
   localparam int PPW  = 2 * PW;
   localparam int CMPW = (PPW > START_W + 1) ? PPW : START_W + 1;
   localparam int OFFW = ((PW > LEN_W) ? PW : LEN_W) + 1;
   localparam int DCW  = $clog2(START_W + 1);

   sps_state_type state_ff, state_in;

   logic [LEN_W-1:0]       csr_len_ff;
   logic                   tbl_ready_ff, tbl_ready_in;
   logic [KW-1:0]          total_ff, total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]      rsp_mask_ff, rsp_mask_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic [START_W-1:0]     start_ff, start_in;
   logic [START_W-1:0]     div_ff, div_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [IW-1:0]          i_ff, i_in;
   logic [IW-1:0]          j_ff, j_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [PW-1:0]          p_ff, p_in;
   logic [PPW-1:0]         pp_ff, pp_in;
   logic [PW-1:0]          rem_ff, rem_in;
   logic [DCW-1:0]         dcnt_ff, dcnt_in;
   logic [OFFW-1:0]        off_ff, off_in;
   logic [WINDOW_BITS-1:0] live_ff, live_in;
   logic [COUNT_W-1:0]     count_ff, count_in;

   logic [PW-1:0]          mul_a;
   logic [PW:0]            rem2;
   logic [IW-1:0]          j_next;
   logic [CMPW-1:0]        end_plus;
   logic [CMPW-1:0]        pp_ext;
   logic [CMPW-1:0]        start_ext;
   logic [CMPW-1:0]        off_diff;
   logic [LEN_W-1:0]       zero_adj;

   logic                   mk_we, mk_wdata, mk_rdata;
   logic [PW-1:0]          mk_waddr;
   logic                   tb_we;
   logic [PW-1:0]          tb_rdata;

   sps_ram #(.WIDTH(1), .DEPTH(BASE_LIMIT)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mk_we),
      .wr_addr (mk_waddr),
      .wr_data (mk_wdata),
      .rd_addr (i_ff[PW-1:0]),
      .rd_data (mk_rdata)
   );

   sps_ram #(.WIDTH(PW), .DEPTH(BASE_TABLE_DEPTH)) u_table_ram (
      .clock   (clock),
      .wr_en   (tb_we),
      .wr_addr (total_ff[TAW-1:0]),
      .wr_data (i_ff[PW-1:0]),
      .rd_addr (k_ff[TAW-1:0]),
      .rd_data (tb_rdata)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.prime_mask  = rsp_mask_ff;
   assign rsp_bus.prime_count = rsp_count_ff;

   always_comb begin
      unique case (state_ff)
         ST_CLEAR, ST_SCAN_RD, ST_SCAN_CHK, ST_BSTRIKE: mul_a = i_ff[PW-1:0];
         default:                                       mul_a = p_ff;
      endcase
   end

   assign pp_in     = PPW'(mul_a) * PPW'(mul_a);
   assign rem2      = {rem_ff, div_ff[START_W-1]};
   assign j_next    = j_ff + i_ff;
   assign pp_ext    = CMPW'(pp_ff);
   assign start_ext = CMPW'(start_ff);
   assign end_plus  = start_ext + CMPW'(len_ff);
   assign off_diff  = pp_ext - start_ext;

   always_comb begin
      if (start_ff == '0) begin
         zero_adj = (len_ff >= LEN_W'(2)) ? LEN_W'(2) : len_ff;
      end else if (start_ff == START_W'(1)) begin
         zero_adj = (len_ff >= LEN_W'(1)) ? LEN_W'(1) : '0;
      end else begin
         zero_adj = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      tbl_ready_in = tbl_ready_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_count_in = rsp_count_ff;
      start_in     = start_ff;
      div_in       = div_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      off_in       = off_ff;
      live_in      = live_ff;
      count_in     = count_ff;
      mk_we        = 1'b0;
      mk_waddr     = j_ff[PW-1:0];
      mk_wdata     = 1'b1;
      tb_we        = 1'b0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               start_in = req_bus.window_start;
               len_in   = (csr_len_ff > LEN_W'(WINDOW_BITS)) ? LEN_W'(WINDOW_BITS)
                                                             : csr_len_ff;
               i_in     = '0;
               state_in = tbl_ready_ff ? ST_WIN_INIT : ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            mk_we    = 1'b1;
            mk_waddr = i_ff[PW-1:0];
            mk_wdata = 1'b0;
            if (i_ff == IW'(BASE_LIMIT - 1)) begin
               i_in     = IW'(2);
               total_in = '0;
               state_in = ST_SCAN_RD;
            end else begin
               i_in = i_ff + IW'(1);
            end
         end
         ST_SCAN_RD: begin
            if (i_ff == IW'(BASE_LIMIT)) begin
               tbl_ready_in = 1'b1;
               state_in     = ST_WIN_INIT;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (mk_rdata) begin
               i_in     = i_ff + IW'(1);
               state_in = ST_SCAN_RD;
            end else begin
               if (total_ff < KW'(BASE_TABLE_DEPTH)) begin
                  tb_we    = 1'b1;
                  total_in = total_ff + KW'(1);
               end
               if (pp_ext < CMPW'(BASE_LIMIT)) begin
                  j_in     = IW'(pp_ff);
                  state_in = ST_BSTRIKE;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_BSTRIKE: begin
            mk_we = 1'b1;
            j_in  = j_next;
            if (j_next >= IW'(BASE_LIMIT)) begin
               i_in     = i_ff + IW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_WIN_INIT: begin
            for (int b = 0; b < WINDOW_BITS; b++) begin
               live_in[b] = (LEN_W'(b) < len_ff);
            end
            if (start_ff == '0) begin
               live_in[0] = 1'b0;
               live_in[1] = 1'b0;
            end else if (start_ff == START_W'(1)) begin
               live_in[0] = 1'b0;
            end
            count_in = len_ff - zero_adj;
            k_in     = '0;
            state_in = (len_ff == '0) ? ST_DONE : ST_P_RD;
         end
         ST_P_RD: begin
            state_in = (k_ff == total_ff) ? ST_DONE : ST_P_LOAD;
         end
         ST_P_LOAD: begin
            p_in     = tb_rdata;
            state_in = ST_P_SQ;
         end
         ST_P_SQ: begin
            state_in = ST_P_CMP;
         end
         ST_P_CMP: begin
            if (pp_ext >= end_plus) begin
               state_in = ST_DONE;
            end else begin
               rem_in   = '0;
               div_in   = start_ff;
               dcnt_in  = DCW'(START_W);
               state_in = ST_P_DIV;
            end
         end
         ST_P_DIV: begin
            rem_in  = (rem2 >= {1'b0, p_ff}) ? PW'(rem2 - {1'b0, p_ff}) : PW'(rem2);
            div_in  = div_ff << 1;
            dcnt_in = dcnt_ff - DCW'(1);
            if (dcnt_ff == DCW'(1)) begin
               state_in = ST_P_OFF;
            end
         end
         ST_P_OFF: begin
            if (pp_ext > start_ext) begin
               off_in = OFFW'(off_diff);
            end else if (rem_ff == '0) begin
               off_in = '0;
            end else begin
               off_in = OFFW'(p_ff - rem_ff);
            end
            state_in = ST_WSTRIKE;
         end
         ST_WSTRIKE: begin
            if (off_ff < OFFW'(len_ff)) begin
               if (live_ff[off_ff[WIW-1:0]]) begin
                  live_in[off_ff[WIW-1:0]] = 1'b0;
                  count_in                 = count_ff - COUNT_W'(1);
               end
               off_in = off_ff + OFFW'(p_ff);
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = ST_P_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = MASK_W'(live_ff);
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_len_ff   <= LEN_RESET;
         tbl_ready_ff <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tbl_ready_ff <= tbl_ready_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_mask_ff  <= rsp_mask_in;
      rsp_count_ff <= rsp_count_in;
      start_ff     <= start_in;
      div_ff       <= div_in;
      len_ff       <= len_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      p_ff         <= p_in;
      pp_ff        <= pp_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      off_ff       <= off_in;
      live_ff      <= live_in;
      count_ff     <= count_in;
   end

endmodule

[rtl/sps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sps_checker.sv]
// Port-level checks of segmented_prime_sieve, bound to the top level.
// Depends on sps_pkg and segmented_prime_sieve.
module sps_checker import sps_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [MASK_W-1:0]  rsp_prime_mask,
   input logic [COUNT_W-1:0] rsp_prime_count
);

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word taken while a window is in work");

   a_count_matches_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_prime_count == COUNT_W'($countones(rsp_prime_mask))))
      else $error("prime count disagrees with bitmap");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_prime_mask)))
      else $error("stalled response word dropped or changed");

endmodule

bind segmented_prime_sieve sps_checker u_sps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_prime_mask  (rsp_bus.prime_mask),
   .rsp_prime_count (rsp_bus.prime_count)
);

[tb/tb_segmented_prime_sieve.sv]
`timescale 1ns / 100ps
// Self-checking bench for segmented_prime_sieve: window starts go in, each result word
// is checked against an in-bench segmented sieve. Needs sps_pkg, sps_req_if, sps_rsp_if
// and the block itself.
module tb_segmented_prime_sieve;
   import sps_pkg::*;

   typedef struct packed {
      logic [MASK_W-1:0]  mask;
      logic [COUNT_W-1:0] count;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;

   sps_req_if req_if ();
   sps_rsp_if rsp_if ();

   segmented_prime_sieve dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [START_W-1:0] pending_starts [$];
   window_result_type  due_windows [$];
   logic [11:0]        small_primes [DEF_BASE_TABLE_DEPTH];
   int                 base_total;
   logic [LEN_W-1:0]   window_length_now = LEN_RESET;
   bit                 steady = 1'b0;
   int                 errors = 0;
   int                 sent = 0;
   int                 checked = 0;
   int                 phases = 1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin : build_small_primes
      bit composite [DEF_BASE_LIMIT];
      base_total = 0;
      for (int i = 2; i < DEF_BASE_LIMIT; i++) begin
         if (!composite[i]) begin
            for (int j = i * i; j < DEF_BASE_LIMIT; j += i) composite[j] = 1'b1;
            if (base_total < DEF_BASE_TABLE_DEPTH) begin
               small_primes[base_total] = 12'(i);
               base_total++;
            end
         end
      end
   end

   function automatic window_result_type sieve_window(logic [START_W-1:0] start,
                                                      logic [LEN_W-1:0] len_reg);
      longint unsigned lo, hi, len, p, m;
      logic [MASK_W-1:0] live;
      window_result_type w;
      w = '0;
      lo = start;
      len = len_reg;
      if (len > DEF_WINDOW_BITS) len = DEF_WINDOW_BITS;
      if (len == 0) return w;
      hi = lo + len - 1;
      live = (len >= 64) ? '1 : ((64'd1 << len) - 64'd1);
      for (int i = 0; i < len && lo + i < 2; i++) live[i] = 1'b0;
      for (int k = 0; k < base_total; k++) begin
         p = small_primes[k];
         if (p * p > hi) break;
         m = ((lo + p - 1) / p) * p;
         if (m < p * p) m = p * p;
         while (m <= hi) begin
            live[m - lo] = 1'b0;
            m += p;
         end
      end
      w.mask = live;
      w.count = COUNT_W'($countones(live));
      return w;
   endfunction

   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            due_windows.push_back(sieve_window(req_if.window_start, window_length_now));
            void'(pending_starts.pop_front());
            sent++;
         end
         if (pending_starts.size() > 0 && (steady || $urandom_range(99, 0) >= 34)) begin
            req_if.valid <= 1'b1;
            req_if.window_start <= pending_starts[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_responses
      window_result_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_windows.size() == 0) begin
               $error("unexpected word: prime_mask %h prime_count %0d",
                      rsp_if.prime_mask, rsp_if.prime_count);
               errors++;
            end else begin
               want = due_windows.pop_front();
               checked++;
               if (rsp_if.prime_mask !== want.mask) begin
                  $error("prime_mask: expected %h, got %h", want.mask, rsp_if.prime_mask);
                  errors++;
               end
               if (rsp_if.prime_count !== want.count) begin
                  $error("prime_count: expected %0d, got %0d", want.count, rsp_if.prime_count);
                  errors++;
               end
            end
         end
         rsp_if.ready <= steady || $urandom_range(99, 0) >= 34;
      end
   end

   task automatic settle();
      do @(negedge clock);
      while (pending_starts.size() != 0 || due_windows.size() != 0 || req_if.valid);
   endtask

   task automatic set_window_length(logic [LEN_W-1:0] len);
      settle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      window_length_now = len;
      phases++;
   endtask

   task automatic add_random_starts(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99, 0);
         if (sel < 60) begin
            pending_starts.push_back(START_W'($urandom_range(4096, 0)));
         end else if (sel < 85) begin
            pending_starts.push_back(START_W'($urandom_range(1 << 20, 0)));
         end else if (sel < 95) begin
            pending_starts.push_back(START_W'($urandom_range(16777152, 0)));
         end else begin
            pending_starts.push_back(START_W'(16777152 - $urandom_range(200, 0)));
         end
      end
   endtask

   initial begin : run_test
      logic [LEN_W-1:0] lengths [8];
      req_if.valid = 1'b0;
      req_if.window_start = '0;
      rsp_if.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset length: edges of the number range, squares of small and large base primes
      pending_starts = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd25, 24'd4064, 24'd65500,
                         24'h555555, 24'hAAAAAA, 24'd16752617, 24'd16777151, 24'd16777152};

      // empty window
      set_window_length(7'd0);
      pending_starts = '{24'd0, 24'd1, 24'd16777152, 24'h3C3C3C};

      set_window_length(7'd1);
      pending_starts = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd16752649, 24'd16777213};

      // saturate to full window
      set_window_length(7'd127);
      pending_starts = '{24'd0, 24'd16777152, 24'h123456};

      lengths = '{7'd64, 7'd65, 7'd2, 7'd63, 7'd0, 7'd0, 7'd0, 7'd32};
      for (int ph = 0; ph < 8; ph++) begin
         if (lengths[ph] == 0) lengths[ph] = LEN_W'($urandom_range(64, 1));
         set_window_length(lengths[ph]);
         steady = (ph == 0);
         add_random_starts(14);
      end
      settle();
      steady = 1'b0;
      repeat (100) @(posedge clock);

      $display("%0d windows sieved across %0d window-length settings, %0d words checked",
               sent, phases, checked);
      if (errors == 0) begin
         $display("tb_segmented_prime_sieve: done, clean");
      end else begin
         $display("tb_segmented_prime_sieve: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #100_000_000;
      $display("tb_segmented_prime_sieve: done, errors");
      $finish;
   end

endmodule

[sim.f]
rtl/sps_pkg.sv
rtl/sps_req_if.sv
rtl/sps_rsp_if.sv
rtl/sps_ram.sv
rtl/segmented_prime_sieve.sv
rtl/sps_checker.sv
tb/tb_segmented_prime_sieve.sv
